FILE: hw/rtl/dst_pkg.sv
// Shared types and constants for the duplicate signature table.
// No dependencies; imported by the slot table top level.
`timescale 1ns / 1ps
`default_nettype none

package dst_pkg;

    localparam int KEY_BASES_DEF = 8;
    localparam int HIST_BINS_DEF = 32;

    localparam int KEY_W     = 16;
    localparam int SIG_W     = 64;
    localparam int GC_W      = 8;
    localparam int COUNT_W   = 32;
    localparam int BINIDX_W  = 5;
    localparam int ENTRY_W   = 17;
    localparam int GCSUM_W   = 24;
    localparam int ACC_W     = 48;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;
    localparam logic [GCSUM_W-1:0] GCSUM_MAX = '1;
    localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [SIG_W-1:0] signature;
        logic [GC_W-1:0]  gc_level;
    } in_item_t;

    typedef struct packed {
        logic [BINIDX_W-1:0] bin_index;
        logic [ENTRY_W-1:0]  bin_entries;
        logic [GCSUM_W-1:0]  bin_gc_sum;
        logic [ACC_W-1:0]    total_reads;
        logic [ACC_W-1:0]    duplicate_reads;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SIG_W-1:0]   signature;
        logic [GC_W-1:0]    gc;
    } slot_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entries;
        logic [GCSUM_W-1:0] gc_sum;
    } bin_acc_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dst_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// Read during a write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/duplicate_signature_table.sv
// Duplicate signature table: slot RAM with read-modify-write adds and a histogram scan.
// Depends on dst_pkg and dst_ram.
//
//  channel   handshake        payload          direction
//  input     start / busy     item   (in_item_t) in
//  result    strobe           result (result_t)  out
//
// Adds may follow each other every cycle while busy is low; a same-slot repeat
// is served from the write forwarding register.
// A report holds busy while it makes one slot RAM read per slot, then one bin
// RAM read per bin; each result passes the bin RAM read and the result register.
// After reset a clearing pass writes every slot, 4^KEY_BASES of them (65536 by
// default), with busy high.
// The receiver cannot stall: each result is on the port for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module duplicate_signature_table #(
    parameter int KEY_BASES = dst_pkg::KEY_BASES_DEF,
    parameter int HIST_BINS = dst_pkg::HIST_BINS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire dst_pkg::in_item_t item,
    output dst_pkg::result_t      result,
    output logic                  strobe
);

    import dst_pkg::*;

    localparam int ADDR_W = 2 * KEY_BASES;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int BIN_W  = $clog2(HIST_BINS);
    localparam int SLOT_W = $bits(slot_t);
    localparam int BACC_W = $bits(bin_acc_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;

    logic                   s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0]      s1_key_reg, s1_key_next;
    logic [SIG_W-1:0]       s1_sig_reg, s1_sig_next;
    logic [GC_W-1:0]        s1_gc_reg, s1_gc_next;

    logic                   fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]      fwd_addr_reg, fwd_addr_next;
    slot_t                  fwd_data_reg, fwd_data_next;

    logic                   sb_valid_reg, sb_valid_next;
    logic                   sc_valid_reg, sc_valid_next;
    logic [BIN_W-1:0]       sc_bin_reg, sc_bin_next;
    logic [GC_W-1:0]        sc_gc_reg, sc_gc_next;

    logic                   bfwd_valid_reg, bfwd_valid_next;
    logic [BIN_W-1:0]       bfwd_bin_reg, bfwd_bin_next;
    bin_acc_t               bfwd_data_reg, bfwd_data_next;
    logic [HIST_BINS-1:0]   bin_vld_reg, bin_vld_next;

    logic [ACC_W-1:0]       total_reg, total_next;
    logic [ACC_W-1:0]       dup_reg, dup_next;

    logic [BIN_W-1:0]       bin_addr_reg, bin_addr_next;
    logic                   em_valid_reg, em_valid_next;
    logic [BIN_W-1:0]       em_bin_reg, em_bin_next;
    logic                   em_last_reg, em_last_next;

    result_t                result_reg, result_next;
    logic                   strobe_reg, strobe_next;

    logic                   accept;
    logic                   slot_we;
    logic [ADDR_W-1:0]      slot_waddr, slot_raddr;
    slot_t                  slot_wdata, slot_rdata, slot_cur, slot_new;

    logic                   bin_we;
    logic [BIN_W-1:0]       bin_raddr, sb_bin;
    bin_acc_t               bin_rdata, bin_cur, bin_new;
    logic [GCSUM_W:0]       gc_sum_wide;
    logic [ACC_W:0]         tot_sum, dup_sum;
    logic                   slot_used;
    bin_acc_t               em_acc;

    dst_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    dst_ram #(
        .WIDTH (BACC_W),
        .DEPTH (HIST_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (sc_bin_reg),
        .wdata (bin_new),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign result = result_reg;
    assign strobe = strobe_reg;

    // slot update for an add transfer
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_key_reg))
        begin
            slot_cur = fwd_data_reg;
        end
        else
        begin
            slot_cur = slot_rdata;
        end

        slot_new = slot_cur;
        if (slot_cur.count == '0)
        begin
            slot_new.count     = COUNT_W'(1);
            slot_new.signature = s1_sig_reg;
            slot_new.gc        = s1_gc_reg;
        end
        else if (slot_cur.signature == s1_sig_reg)
        begin
            if (slot_cur.count != COUNT_MAX)
            begin
                slot_new.count = slot_cur.count + COUNT_W'(1);
            end
        end
        else if (slot_cur.signature > s1_sig_reg)
        begin
            slot_new.count     = COUNT_W'(1);
            slot_new.signature = s1_sig_reg;
            slot_new.gc        = s1_gc_reg;
        end
    end

    always_comb
    begin
        slot_raddr = (state_reg == ST_SCAN) ? addr_reg : ADDR_W'(item.key);
        if (state_reg == ST_CLEAR)
        begin
            slot_we    = 1'b1;
            slot_waddr = addr_reg;
            slot_wdata = '0;
        end
        else
        begin
            slot_we    = s1_valid_reg;
            slot_waddr = s1_key_reg;
            slot_wdata = slot_new;
        end
    end

    // scan stage: bin select and running totals
    always_comb
    begin
        slot_used = sb_valid_reg && (slot_rdata.count != '0);
        if (slot_rdata.count >= COUNT_W'(HIST_BINS))
        begin
            sb_bin = BIN_W'(HIST_BINS - 1);
        end
        else
        begin
            sb_bin = BIN_W'(slot_rdata.count);
        end
        tot_sum   = {1'b0, total_reg} + (ACC_W + 1)'(slot_rdata.count);
        dup_sum   = {1'b0, dup_reg} + (ACC_W + 1)'(slot_rdata.count - COUNT_W'(1));
        bin_raddr = (state_reg == ST_EMIT) ? bin_addr_reg : sb_bin;
    end

    // bin accumulate stage
    always_comb
    begin
        if (bfwd_valid_reg && (bfwd_bin_reg == sc_bin_reg))
        begin
            bin_cur = bfwd_data_reg;
        end
        else if (bin_vld_reg[sc_bin_reg])
        begin
            bin_cur = bin_rdata;
        end
        else
        begin
            bin_cur = '0;
        end

        bin_new = bin_cur;
        if (bin_cur.entries != ENTRY_MAX)
        begin
            bin_new.entries = bin_cur.entries + ENTRY_W'(1);
        end
        gc_sum_wide = {1'b0, bin_cur.gc_sum} + (GCSUM_W + 1)'(sc_gc_reg);
        if (gc_sum_wide[GCSUM_W])
        begin
            bin_new.gc_sum = GCSUM_MAX;
        end
        else
        begin
            bin_new.gc_sum = gc_sum_wide[GCSUM_W-1:0];
        end
        bin_we = sc_valid_reg;
        em_acc = bin_vld_reg[em_bin_reg] ? bin_rdata : '0;
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        s1_valid_next   = 1'b0;
        s1_key_next     = ADDR_W'(item.key);
        s1_sig_next     = item.signature;
        s1_gc_next      = item.gc_level;
        fwd_valid_next  = s1_valid_reg;
        fwd_addr_next   = s1_key_reg;
        fwd_data_next   = slot_new;
        sb_valid_next   = (state_reg == ST_SCAN);
        sc_valid_next   = slot_used;
        sc_bin_next     = sb_bin;
        sc_gc_next      = slot_rdata.gc;
        bfwd_valid_next = sc_valid_reg;
        bfwd_bin_next   = sc_bin_reg;
        bfwd_data_next  = bin_new;
        bin_vld_next    = bin_vld_reg;
        total_next      = total_reg;
        dup_next        = dup_reg;
        bin_addr_next   = bin_addr_reg;
        em_valid_next   = 1'b0;
        em_bin_next     = bin_addr_reg;
        em_last_next    = (bin_addr_reg == BIN_W'(HIST_BINS - 1));
        strobe_next     = em_valid_reg;

        result_next.bin_index       = BINIDX_W'(em_bin_reg);
        result_next.bin_entries     = em_acc.entries;
        result_next.bin_gc_sum      = em_acc.gc_sum;
        result_next.total_reads     = total_reg;
        result_next.duplicate_reads = dup_reg;
        result_next.last            = em_last_reg;

        if (sc_valid_reg)
        begin
            bin_vld_next[sc_bin_reg] = 1'b1;
        end
        if (slot_used)
        begin
            total_next = tot_sum[ACC_W] ? ACC_MAX : tot_sum[ACC_W-1:0];
            dup_next   = dup_sum[ACC_W] ? ACC_MAX : dup_sum[ACC_W-1:0];
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_REPORT)
                    begin
                        state_next   = ST_SCAN;
                        addr_next    = '0;
                        bin_vld_next = '0;
                        total_next   = '0;
                        dup_next     = '0;
                    end
                    else
                    begin
                        s1_valid_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == '1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sb_valid_reg && !sc_valid_reg)
                begin
                    state_next    = ST_EMIT;
                    bin_addr_next = '0;
                end
            end
            ST_EMIT:
            begin
                em_valid_next = 1'b1;
                if (bin_addr_reg == BIN_W'(HIST_BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    bin_addr_next = bin_addr_reg + BIN_W'(1);
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_key_reg     <= '0;
            s1_sig_reg     <= '0;
            s1_gc_reg      <= '0;
            fwd_valid_reg  <= 1'b0;
            fwd_addr_reg   <= '0;
            fwd_data_reg   <= '0;
            sb_valid_reg   <= 1'b0;
            sc_valid_reg   <= 1'b0;
            sc_bin_reg     <= '0;
            sc_gc_reg      <= '0;
            bfwd_valid_reg <= 1'b0;
            bfwd_bin_reg   <= '0;
            bfwd_data_reg  <= '0;
            bin_vld_reg    <= '0;
            total_reg      <= '0;
            dup_reg        <= '0;
            bin_addr_reg   <= '0;
            em_valid_reg   <= 1'b0;
            em_bin_reg     <= '0;
            em_last_reg    <= 1'b0;
            result_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            s1_valid_reg   <= s1_valid_next;
            s1_key_reg     <= s1_key_next;
            s1_sig_reg     <= s1_sig_next;
            s1_gc_reg      <= s1_gc_next;
            fwd_valid_reg  <= fwd_valid_next;
            fwd_addr_reg   <= fwd_addr_next;
            fwd_data_reg   <= fwd_data_next;
            sb_valid_reg   <= sb_valid_next;
            sc_valid_reg   <= sc_valid_next;
            sc_bin_reg     <= sc_bin_next;
            sc_gc_reg      <= sc_gc_next;
            bfwd_valid_reg <= bfwd_valid_next;
            bfwd_bin_reg   <= bfwd_bin_next;
            bfwd_data_reg  <= bfwd_data_next;
            bin_vld_reg    <= bin_vld_next;
            total_reg      <= total_next;
            dup_reg        <= dup_next;
            bin_addr_reg   <= bin_addr_next;
            em_valid_reg   <= em_valid_next;
            em_bin_reg     <= em_bin_next;
            em_last_reg    <= em_last_next;
            result_reg     <= result_next;
            strobe_reg     <= strobe_next;
        end
    end

`ifndef SYNTH
    a_add_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == ST_IDLE))
        else $error("add write without an idle transfer");

    a_scan_stage_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        sb_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("scan stage active outside scan");

    a_no_bin_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        sc_valid_reg |-> state_reg != ST_EMIT)
        else $error("bin write overlaps emit");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |-> result_reg.bin_index == BINIDX_W'(HIST_BINS - 1))
        else $error("last flag on wrong bin");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last) |=> !strobe_reg)
        else $error("result after last bin");
`endif

endmodule

`default_nettype wire
